/* src/atp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types and constants of the text terminal escape parser.
// ----------------------------------------------------------------------------
package atp_pkg;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_CSI_START,
    PH_CSI_PARAM
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TEXT,
    OP_ESC,
    OP_CSI
  } op_e;

  typedef enum logic [1:0] {
    SGR_KEEP,
    SGR_NORMAL,
    SGR_BRIGHT,
    SGR_REVERSE
  } sgr_e;

  typedef enum logic [2:0] {
    KIND_CURSOR,
    KIND_WRITE,
    KIND_ERASE,
    KIND_SCROLL_UP,
    KIND_SCROLL_DOWN,
    KIND_DELETE,
    KIND_INSERT,
    KIND_BEEP
  } kind_e;

  typedef enum logic [1:0] {
    REG_COLUMNS,
    REG_LINES,
    REG_ERASE_CELL,
    REG_UNUSED
  } reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_SECOND
  } back_state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    sgr_e       sgr;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] count;
    logic [15:0] cell_res;
    logic [7:0]  region_top;
    logic [7:0]  region_bottom;
    logic [7:0]  cursor_x;
    logic [7:0]  cursor_y;
    logic        last;
  } res_t;

  localparam logic [7:0] ATTR_NORMAL  = 8'h07;
  localparam logic [7:0] ATTR_BRIGHT  = 8'h0f;
  localparam logic [7:0] ATTR_REVERSE = 8'h70;
  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [7:0] RESET_LINES   = 8'd25;
  localparam logic [15:0] RESET_ERASE  = 16'h0720;

  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UB     = 8'h42;
  localparam logic [7:0] CH_UC     = 8'h43;
  localparam logic [7:0] CH_UD     = 8'h44;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UG     = 8'h47;
  localparam logic [7:0] CH_UH     = 8'h48;
  localparam logic [7:0] CH_UJ     = 8'h4a;
  localparam logic [7:0] CH_UK     = 8'h4b;
  localparam logic [7:0] CH_UL     = 8'h4c;
  localparam logic [7:0] CH_UM     = 8'h4d;
  localparam logic [7:0] CH_UP     = 8'h50;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_GRAVE  = 8'h60;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LD     = 8'h64;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF_F   = 8'h66;
  localparam logic [7:0] CH_LM     = 8'h6d;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LS     = 8'h73;
  localparam logic [7:0] CH_LU     = 8'h75;

  function automatic res_t mk_res(kind_e kind, logic [7:0] row, logic [7:0] col,
                                  logic [15:0] count, logic [15:0] cell_val,
                                  logic [7:0] rt, logic [7:0] rb,
                                  logic [7:0] cx, logic [7:0] cy);
    res_t r;
    r.kind          = kind;
    r.row           = row;
    r.col           = col;
    r.count         = count;
    r.cell_res      = cell_val;
    r.region_top    = rt;
    r.region_bottom = rb;
    r.cursor_x      = cx;
    r.cursor_y      = cy;
    r.last          = 1'b1;
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/atp_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// atp_fifo
// Two-entry queue that decouples the parser front from the command back end.
// ----------------------------------------------------------------------------
module atp_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

/* src/atp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// atp_front
// Escape sequence parser: classifies each byte and collects CSI parameters.
// ----------------------------------------------------------------------------
module atp_front import atp_pkg::*; #(
  parameter int MAX_PARAMS = 16,
  parameter int PARAM_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  byte_valid_i,
  output logic                       byte_ready_o,
  input  wire logic [7:0]            byte_i,
  output logic                       cmd_valid_o,
  input  wire logic                  cmd_ready_i,
  output cmd_t                       cmd_o,
  output logic [PARAM_BITS-1:0]      p0_o,
  output logic [PARAM_BITS-1:0]      p1_o
);

  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PARAMS - 1);

  phase_e                phase_q, phase_d;
  logic [IW-1:0]         idx_q, idx_d, idx_c;
  logic [PARAM_BITS-1:0] acc_q, acc_d, acc_c;
  logic [PARAM_BITS-1:0] p0_q, p0_d, p0_c;
  logic [PARAM_BITS-1:0] p1_q, p1_d, p1_c;
  sgr_e                  sgr_q, sgr_d, sgr_c, sgr_fin;
  logic [PARAM_BITS+3:0] mul10;
  logic                  accept;

  function automatic sgr_e sgr_update(sgr_e cur, logic [PARAM_BITS-1:0] v);
    sgr_e r;
    r = cur;
    if (v == PARAM_BITS'(0) || v == PARAM_BITS'(27)) begin
      r = SGR_NORMAL;
    end else if (v == PARAM_BITS'(1) || v == PARAM_BITS'(4)) begin
      r = SGR_BRIGHT;
    end else if (v == PARAM_BITS'(7)) begin
      r = SGR_REVERSE;
    end
    return r;
  endfunction

  assign accept       = byte_valid_i && cmd_ready_i;
  assign byte_ready_o = cmd_ready_i;
  assign cmd_valid_o  = byte_valid_i;

  always_comb begin
    if (phase_q == PH_CSI_START) begin
      idx_c = '0;
      acc_c = '0;
      p0_c  = '0;
      p1_c  = '0;
      sgr_c = SGR_KEEP;
    end else begin
      idx_c = idx_q;
      acc_c = acc_q;
      p0_c  = p0_q;
      p1_c  = p1_q;
      sgr_c = sgr_q;
    end
    mul10 = {1'b0, acc_c, 3'b000} + {3'b000, acc_c, 1'b0}
          + {{PARAM_BITS{1'b0}}, byte_i[3:0]};
    sgr_fin = sgr_update(sgr_c, acc_c);

    phase_d   = phase_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    sgr_d     = sgr_q;
    cmd_o.op  = OP_NONE;
    cmd_o.ch  = byte_i;
    cmd_o.sgr = sgr_fin;
    p0_o      = (idx_c == IW'(0)) ? acc_c : p0_c;
    p1_o      = (idx_c == IW'(1)) ? acc_c : p1_c;

    case (phase_q)
      PH_TEXT: begin
        if (byte_i == CH_ESC) begin
          phase_d = PH_ESC;
        end else begin
          cmd_o.op = OP_TEXT;
        end
      end
      PH_ESC: begin
        if (byte_i == CH_LBRACK) begin
          phase_d = PH_CSI_START;
        end else begin
          phase_d  = PH_TEXT;
          cmd_o.op = OP_ESC;
        end
      end
      PH_CSI_START, PH_CSI_PARAM: begin
        phase_d = PH_CSI_PARAM;
        idx_d   = idx_c;
        acc_d   = acc_c;
        p0_d    = p0_c;
        p1_d    = p1_c;
        sgr_d   = sgr_c;
        if (phase_q == PH_CSI_START && byte_i == CH_QUEST) begin
          phase_d = PH_CSI_PARAM;
        end else if (byte_i == CH_SEMI && idx_c != LAST_IDX) begin
          if (idx_c == IW'(0)) begin
            p0_d = acc_c;
          end
          if (idx_c == IW'(1)) begin
            p1_d = acc_c;
          end
          sgr_d = sgr_fin;
          acc_d = '0;
          idx_d = idx_c + IW'(1);
        end else if (byte_i >= CH_0 && byte_i <= CH_9) begin
          if (|mul10[PARAM_BITS+3:PARAM_BITS]) begin
            acc_d = '1;
          end else begin
            acc_d = mul10[PARAM_BITS-1:0];
          end
        end else begin
          phase_d  = PH_TEXT;
          cmd_o.op = OP_CSI;
        end
      end
      default: begin
        phase_d = PH_TEXT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TEXT;
      idx_q   <= '0;
      acc_q   <= '0;
      p0_q    <= '0;
      p1_q    <= '0;
      sgr_q   <= SGR_KEEP;
    end else if (accept) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      acc_q   <= acc_d;
      p0_q    <= p0_d;
      p1_q    <= p1_d;
      sgr_q   <= sgr_d;
    end
  end

endmodule
`default_nettype wire

/* src/atp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// atp_back
// Command back end: cursor, scroll region and attribute state, screen
// command generation and the output register.
// ----------------------------------------------------------------------------
module atp_back import atp_pkg::*; #(
  parameter int PARAM_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [15:0]           cfg_data_i,
  input  wire logic                  cmd_valid_i,
  output logic                       cmd_ready_o,
  input  wire cmd_t                  cmd_i,
  input  wire logic [PARAM_BITS-1:0] p0_i,
  input  wire logic [PARAM_BITS-1:0] p1_i,
  output logic                       res_valid_o,
  input  wire logic                  res_ready_i,
  output res_t                       res_o
);

  localparam int PW = PARAM_BITS;
  localparam int SW = PARAM_BITS + 2;

  back_state_e state_q, state_d;
  logic [7:0]  columns_q, lines_q;
  logic [15:0] erase_q;
  logic [7:0]  x_q, x_d, y_q, y_d, st_q, st_d, sb_q, sb_d;
  logic [7:0]  attr_q, attr_d, sc_q, sc_d, sr_q, sr_d;
  cmd_t        cmd_q;
  logic [PW-1:0] p0_q, p1_q;
  logic [15:0] prod_lc_q, prod_yc_q;
  res_t        res_q, res_d, res2_q, r1, r2, scroll_r, wr_r;
  logic        res_valid_q, res_valid_d;
  logic        e1, e2, can_load, lf_adv;
  logic [7:0]  x1, yw, xw, xt;
  logic [8:0]  tab9, tabw;
  logic [16:0] lin;
  logic [15:0] cells;
  logic [PW-1:0] one_u, p0m1, p1m1, q1, clamp_src;
  logic [7:0]  clamp_l, clamp_c;
  logic [SW-1:0] tx, ty, xs, ys, ones, p0s, p1s, cs, ls;
  logic        mv, mv_ok;

  assign can_load    = !res_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == BK_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    lf_adv    = ({1'b0, y_q} + 9'd1) < {1'b0, sb_q};
    one_u     = (p0_q != '0) ? p0_q : PW'(1);
    p0m1      = (p0_q != '0) ? p0_q - PW'(1) : '0;
    p1m1      = (p1_q != '0) ? p1_q - PW'(1) : '0;
    q1        = (p1_q != '0) ? p1_q : {{(PW-8){1'b0}}, lines_q};
    clamp_src = (p0_q != '0) ? p0_q : PW'(1);
    clamp_l   = (clamp_src > {{(PW-8){1'b0}}, lines_q}) ? lines_q : clamp_src[7:0];
    clamp_c   = (clamp_src > {{(PW-8){1'b0}}, columns_q}) ? columns_q : clamp_src[7:0];
    xs        = {{(SW-8){1'b0}}, x_q};
    ys        = {{(SW-8){1'b0}}, y_q};
    cs        = {{(SW-8){1'b0}}, columns_q};
    ls        = {{(SW-8){1'b0}}, lines_q};
    ones      = {2'b00, one_u};
    p0s       = {2'b00, p0m1};
    p1s       = {2'b00, p1m1};
    lin       = {1'b0, prod_yc_q} + {9'd0, x_q};
    cells     = ({1'b0, prod_lc_q} >= lin) ? prod_lc_q - lin[15:0] : 16'd0;
    x1        = (x_q >= columns_q) ? x_q - columns_q : x_q;
    tab9      = {1'b0, x_q} + 9'd8 - {6'd0, x_q[2:0]};
    tabw      = (tab9 > {1'b0, columns_q}) ? tab9 - {1'b0, columns_q} : tab9;
    xt        = tabw[8] ? 8'hff : tabw[7:0];
    scroll_r  = mk_res(KIND_SCROLL_UP, 8'd0, 8'd0, 16'd1, erase_q, st_q, sb_q, x_q, y_q);
    wr_r      = scroll_r;
    yw        = y_q;
    xw        = x_q;

    x_d = x_q; y_d = y_q; st_d = st_q; sb_d = sb_q;
    attr_d = attr_q; sc_d = sc_q; sr_d = sr_q;
    e1 = 1'b0; e2 = 1'b0; r1 = scroll_r; r2 = scroll_r;
    mv = 1'b0; tx = xs; ty = ys;

    case (cmd_q.op)
      OP_TEXT: begin
        if (cmd_q.ch >= CH_SPACE && cmd_q.ch <= CH_TILDE) begin
          if (x_q >= columns_q) begin
            if (lf_adv) begin
              yw = y_q + 8'd1;
            end else begin
              e1 = 1'b1;
              r1 = scroll_r;
              r1.cursor_x = x1;
            end
          end
          xw   = (x1 == 8'hff) ? 8'hff : x1 + 8'd1;
          wr_r = mk_res(KIND_WRITE, yw, x1, 16'd0, {attr_q, cmd_q.ch}, st_q, sb_q, xw, yw);
          if (e1) begin
            e2 = 1'b1;
            r2 = wr_r;
          end else begin
            e1 = 1'b1;
            r1 = wr_r;
          end
          x_d = xw;
          y_d = yw;
        end else if (cmd_q.ch == CH_LF || cmd_q.ch == CH_VT || cmd_q.ch == CH_FF) begin
          if (lf_adv) begin
            y_d = y_q + 8'd1;
          end else begin
            e1 = 1'b1;
          end
        end else if (cmd_q.ch == CH_CR) begin
          x_d = 8'd0;
        end else if (cmd_q.ch == CH_BS) begin
          if (x_q != 8'd0) begin
            x_d = x_q - 8'd1;
          end
        end else if (cmd_q.ch == CH_TAB) begin
          x_d = xt;
          if (tab9 > {1'b0, columns_q}) begin
            if (lf_adv) begin
              y_d = y_q + 8'd1;
            end else begin
              e1 = 1'b1;
              r1.cursor_x = xt;
            end
          end
        end else if (cmd_q.ch == CH_BEL) begin
          e1 = 1'b1;
          r1 = mk_res(KIND_BEEP, 8'd0, 8'd0, 16'd0, 16'd0, st_q, sb_q, x_q, y_q);
        end
      end
      OP_ESC: begin
        case (cmd_q.ch)
          CH_UE: begin
            mv = 1'b1; tx = '0; ty = ys + SW'(1);
          end
          CH_UD: begin
            if (lf_adv) begin
              y_d = y_q + 8'd1;
            end else begin
              e1 = 1'b1;
            end
          end
          CH_7: begin
            sc_d = x_q; sr_d = y_q;
          end
          CH_8: begin
            mv = 1'b1;
            tx = {{(SW-8){1'b0}}, sc_q};
            ty = {{(SW-8){1'b0}}, sr_q};
          end
          default: ;
        endcase
      end
      OP_CSI: begin
        case (cmd_q.ch)
          CH_UG, CH_GRAVE: begin mv = 1'b1; tx = p0s; end
          CH_UA: begin mv = 1'b1; ty = ys - ones; end
          CH_UB, CH_LE: begin mv = 1'b1; ty = ys + ones; end
          CH_UC, CH_LA: begin mv = 1'b1; tx = xs + ones; end
          CH_UD: begin mv = 1'b1; tx = xs - ones; end
          CH_UE: begin mv = 1'b1; tx = '0; ty = ys + ones; end
          CH_UF: begin mv = 1'b1; tx = '0; ty = ys - ones; end
          CH_LD: begin mv = 1'b1; ty = p0s; end
          CH_UH, CH_LF_F: begin mv = 1'b1; tx = p1s; ty = p0s; end
          CH_LU: begin
            mv = 1'b1;
            tx = {{(SW-8){1'b0}}, sc_q};
            ty = {{(SW-8){1'b0}}, sr_q};
          end
          CH_LS: begin sc_d = x_q; sr_d = y_q; end
          CH_UJ: begin
            if (p0_q == PW'(0)) begin
              e1 = 1'b1;
              r1 = mk_res(KIND_ERASE, y_q, x_q, cells, erase_q, st_q, sb_q, x_q, y_q);
            end else if (p0_q == PW'(1)) begin
              e1 = 1'b1;
              r1 = mk_res(KIND_ERASE, 8'd0, 8'd0, lin[15:0], erase_q, st_q, sb_q, x_q, y_q);
            end else if (p0_q == PW'(2)) begin
              e1 = 1'b1;
              r1 = mk_res(KIND_ERASE, 8'd0, 8'd0, prod_lc_q, erase_q, st_q, sb_q, x_q, y_q);
            end
          end
          CH_UK: begin
            if (p0_q == PW'(0)) begin
              if (x_q < columns_q) begin
                e1 = 1'b1;
                r1 = mk_res(KIND_ERASE, y_q, x_q, {8'd0, columns_q - x_q}, erase_q,
                            st_q, sb_q, x_q, y_q);
              end
            end else if (p0_q == PW'(1)) begin
              e1 = 1'b1;
              r1 = mk_res(KIND_ERASE, y_q, 8'd0,
                          {8'd0, (x_q < columns_q) ? x_q : columns_q}, erase_q,
                          st_q, sb_q, x_q, y_q);
            end else if (p0_q == PW'(2)) begin
              e1 = 1'b1;
              r1 = mk_res(KIND_ERASE, y_q, 8'd0, {8'd0, columns_q}, erase_q,
                          st_q, sb_q, x_q, y_q);
            end
          end
          CH_UL, CH_UM: begin
            if (y_q < lines_q) begin
              e1 = 1'b1;
              r1 = mk_res((cmd_q.ch == CH_UL) ? KIND_SCROLL_DOWN : KIND_SCROLL_UP,
                          8'd0, 8'd0, {8'd0, clamp_l}, erase_q, y_q, lines_q, x_q, y_q);
            end
          end
          CH_UP, CH_AT: begin
            if (x_q < columns_q) begin
              e1 = 1'b1;
              r1 = mk_res((cmd_q.ch == CH_UP) ? KIND_DELETE : KIND_INSERT,
                          y_q, x_q, {8'd0, clamp_c}, erase_q, st_q, sb_q, x_q, y_q);
            end
          end
          CH_LM: begin
            case (cmd_q.sgr)
              SGR_NORMAL:  attr_d = ATTR_NORMAL;
              SGR_BRIGHT:  attr_d = ATTR_BRIGHT;
              SGR_REVERSE: attr_d = ATTR_REVERSE;
              default:     attr_d = attr_q;
            endcase
          end
          CH_LR: begin
            if (p0m1 < q1 && q1 <= {{(PW-8){1'b0}}, lines_q}) begin
              st_d = p0m1[7:0];
              sb_d = q1[7:0];
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    mv_ok = !tx[SW-1] && !ty[SW-1] && (tx <= cs) && (ty < ls);
    if (mv && mv_ok) begin
      x_d = tx[7:0];
      y_d = ty[7:0];
    end
    if (!e1) begin
      r1 = mk_res(KIND_CURSOR, 8'd0, 8'd0, 16'd0, 16'd0, st_d, sb_d, x_d, y_d);
    end
    r1.last = !e2;
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (can_load) begin
          res_d       = r1;
          res_valid_d = 1'b1;
          state_d     = e2 ? BK_SECOND : BK_IDLE;
        end
      end
      BK_SECOND: begin
        if (can_load) begin
          res_d       = res2_q;
          res_valid_d = 1'b1;
          state_d     = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
      columns_q   <= RESET_COLUMNS;
      lines_q     <= RESET_LINES;
      erase_q     <= RESET_ERASE;
      x_q         <= 8'd0;
      y_q         <= 8'd0;
      st_q        <= 8'd0;
      sb_q        <= RESET_LINES;
      attr_q      <= ATTR_NORMAL;
      sc_q        <= 8'd0;
      sr_q        <= 8'd0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i == REG_COLUMNS) begin
          columns_q <= cfg_data_i[7:0];
        end
        if (cfg_index_i == REG_LINES) begin
          lines_q <= cfg_data_i[7:0];
        end
        if (cfg_index_i == REG_ERASE_CELL) begin
          erase_q <= cfg_data_i;
        end
      end
      if (state_q == BK_EXEC && can_load) begin
        x_q    <= x_d;
        y_q    <= y_d;
        st_q   <= st_d;
        sb_q   <= sb_d;
        attr_q <= attr_d;
        sc_q   <= sc_d;
        sr_q   <= sr_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (state_q == BK_IDLE && cmd_valid_i) begin
      cmd_q     <= cmd_i;
      p0_q      <= p0_i;
      p1_q      <= p1_i;
      prod_lc_q <= {8'd0, lines_q} * {8'd0, columns_q};
      prod_yc_q <= {8'd0, y_q} * {8'd0, columns_q};
    end
    if (state_q == BK_EXEC && can_load) begin
      res2_q <= r2;
    end
  end

  a_second_has_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SECOND |-> res_valid_q)
    else $error("second command pending without a first one on the output");

  a_pop_starts_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_o |=> state_q == BK_EXEC)
    else $error("popped command did not start execution");

  a_not_last_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.last |-> state_q == BK_SECOND)
    else $error("non-final beat shown without a follow-up pending");

  a_region_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q < sb_q)
    else $error("scroll region top is not above its bottom");

endmodule
`default_nettype wire

/* src/ansi_text_terminal_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_text_terminal_parser
// Text console byte parser with ESC/CSI handling that turns each byte into
// one or two screen commands.
// ----------------------------------------------------------------------------
// A command beat passes through the queue, the back end's command register and
// its output register. The back end takes a byte from the queue only while idle
// and finishes each byte, also one that yields two commands, before the next.
// Reset: asynchronous; cursor home, region top 0 and bottom 25, attribute 0x07,
// 80 columns, 25 lines, erase cell 0x0720, parser in text mode.
// ----------------------------------------------------------------------------
module ansi_text_terminal_parser import atp_pkg::*; #(
  parameter int MAX_PARAMS = 16,
  parameter int PARAM_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       row_o,
  output logic [7:0]       col_o,
  output logic [15:0]      count_o,
  output logic [15:0]      cell_res_o,
  output logic [7:0]       region_top_o,
  output logic [7:0]       region_bottom_o,
  output logic [7:0]       cursor_x_o,
  output logic [7:0]       cursor_y_o,
  output logic             last_o
);

  localparam int QW = $bits(cmd_t) + 2 * PARAM_BITS;

  cmd_t                  f_cmd, b_cmd;
  logic [PARAM_BITS-1:0] f_p0, f_p1, b_p0, b_p1;
  logic                  f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0]         q_out;
  res_t                  res;

  atp_front #(
    .MAX_PARAMS(MAX_PARAMS),
    .PARAM_BITS(PARAM_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_valid_i),
    .byte_ready_o (in_ready_o),
    .byte_i       (byte_in_i),
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_o        (f_cmd),
    .p0_o         (f_p0),
    .p1_o         (f_p1)
  );

  atp_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_cmd, f_p0, f_p1}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  assign b_cmd = q_out[QW-1 -: $bits(cmd_t)];
  assign b_p0  = q_out[2*PARAM_BITS-1 -: PARAM_BITS];
  assign b_p1  = q_out[PARAM_BITS-1:0];

  atp_back #(
    .PARAM_BITS(PARAM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .p0_i        (b_p0),
    .p1_i        (b_p1),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o          = res.kind;
  assign row_o           = res.row;
  assign col_o           = res.col;
  assign count_o         = res.count;
  assign cell_res_o      = res.cell_res;
  assign region_top_o    = res.region_top;
  assign region_bottom_o = res.region_bottom;
  assign cursor_x_o      = res.cursor_x;
  assign cursor_y_o      = res.cursor_y;
  assign last_o          = res.last;

endmodule
`default_nettype wire
